FILE: hdl/cff_pkg.sv
// ----------------------------------------------------------------------------
// cff_pkg
// Shared types and constants for the circular FIR filter: field widths,
// operation codes and the control bundle between sequencer and MAC unit.
// ----------------------------------------------------------------------------
package cff_pkg;

  localparam int unsigned MAX_TAPS_DEF = 8;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned COEF_W       = 16;
  localparam int unsigned PROD_W       = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W        = 40;
  localparam int unsigned FRAC_W       = 15;
  localparam int unsigned TAP_CNT_W    = 4;
  localparam int unsigned COEF_IDX_W   = 3;

  localparam logic [TAP_CNT_W-1:0] TAP_CNT_RST = 4'd8;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_COEF   = 1'b1
  } op_e;

  typedef struct packed {
    logic clear;   // start of a new sum
    logic mul_en;  // operands on the store outputs are valid
  } mac_ctrl_t;

endpackage

FILE: hdl/cff_store.sv
// ----------------------------------------------------------------------------
// cff_store
// Small sample or coefficient store: one write port, one registered read
// port, and a valid bit per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module cff_store import cff_pkg::*; #(
  parameter int unsigned DEPTH = MAX_TAPS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic signed [SAMPLE_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic signed [SAMPLE_W-1:0] rdata_o
);

  logic signed [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]           valid_q;
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic                       rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvld_q <= valid_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // an entry never written since reset reads as zero
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

FILE: hdl/cff_mac.sv
// ----------------------------------------------------------------------------
// cff_mac
// Shared multiply-accumulate unit: one registered 16x16 product per cycle,
// a 40-bit accumulator, and floor scaling by 2^-15 with saturation.
// ----------------------------------------------------------------------------
module cff_mac import cff_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mac_ctrl_t                  ctrl_i,
  input  logic signed [COEF_W-1:0]   coef_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic signed [SAMPLE_W-1:0] result_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  shifted;
  logic                     fits;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.mul_en & ~ctrl_i.clear;
      acc_q      <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * sample_i;
  end

  // arithmetic shift gives floor; saturate when upper bits are not all sign
  assign shifted  = acc_q >>> FRAC_W;
  assign fits     = (&shifted[ACC_W-1:SAMPLE_W-1]) | ~(|shifted[ACC_W-1:SAMPLE_W-1]);
  assign result_o = fits ? shifted[SAMPLE_W-1:0]
                         : (shifted[ACC_W-1] ? SAT_MIN : SAT_MAX);

endmodule

FILE: hdl/circular_fir_filter_top.sv
// ----------------------------------------------------------------------------
// circular_fir_filter_top
// Direct-form FIR filter over a circular sample store, one tap per cycle
// through a shared multiply-accumulate unit under a small sequencer.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   operation, sample,
//                                                 coef_index, coef_value
//   out      output     out_valid_o / out_ready_i filtered
//   cfg      input      cfg_we_i                  cfg_wdata_i (tap_count)
//
// A coefficient write is done in the idle state. A sample steps through
// ST_MAC one tap per cycle over the single read port of each store and the
// shared multiplier, then ST_DRAIN1 and ST_DRAIN2 for the read and product
// registers, then ST_DONE. Reset clears the valid bits of both stores at
// once; there is no clearing pass. The result sits in an output register; a
// new result waits in ST_DONE while the previous one has not been taken.
// ----------------------------------------------------------------------------
module circular_fir_filter_top import cff_pkg::*; #(
  parameter int unsigned MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         operation_i,
  input  logic signed [SAMPLE_W-1:0]   sample_i,
  input  logic [COEF_IDX_W-1:0]        coef_index_i,
  input  logic signed [COEF_W-1:0]     coef_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SAMPLE_W-1:0]   filtered_o,
  input  logic                         cfg_we_i,
  input  logic [TAP_CNT_W-1:0]         cfg_wdata_i
);

  localparam int unsigned PW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CW = $clog2(MAX_TAPS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_DONE
  } state_e;

  state_e                     state_q, state_d;
  logic [TAP_CNT_W-1:0]       tap_count_q;
  logic [PW-1:0]              wp_q, wp_d;
  logic [CW-1:0]              n_q, n_d;
  logic [PW-1:0]              k_q, k_d;
  logic [PW-1:0]              idx_q, idx_d;
  logic                       rd_vld_q, rd_vld_d;
  logic                       out_vld_q, out_vld_d;
  logic signed [SAMPLE_W-1:0] filtered_q, filtered_d;

  logic                       accept;
  logic                       smp_accept;
  logic                       coef_we;
  logic [CW-1:0]              n_cur;
  logic [PW-1:0]              pos0;
  logic [CW-1:0]              pos_inc;
  logic [CW-1:0]              idx_inc;
  logic signed [SAMPLE_W-1:0] smp_rd;
  logic signed [COEF_W-1:0]   coef_rd;
  logic signed [SAMPLE_W-1:0] mac_res;
  mac_ctrl_t                  mac_ctrl;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign smp_accept = accept & (operation_i == OP_FILTER);
  assign coef_we    = accept & (operation_i == OP_COEF) &
                      (32'(coef_index_i) < MAX_TAPS);

  // taps in use: zero counts as one, clamp at the store depth
  always_comb begin
    if (tap_count_q == '0) begin
      n_cur = CW'(1);
    end else if (32'(tap_count_q) > MAX_TAPS) begin
      n_cur = CW'(MAX_TAPS);
    end else begin
      n_cur = CW'(tap_count_q);
    end
  end

  // position left beyond a shrunk tap count restarts at zero
  assign pos0    = (CW'(wp_q) >= n_cur) ? '0 : wp_q;
  assign pos_inc = CW'(pos0) + CW'(1);
  assign idx_inc = CW'(idx_q) + CW'(1);

  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    n_d        = n_q;
    k_d        = k_q;
    idx_d      = idx_q;
    rd_vld_d   = 1'b0;
    out_vld_d  = out_vld_q;
    filtered_d = filtered_q;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (smp_accept) begin
          n_d     = n_cur;
          wp_d    = (pos_inc >= n_cur) ? '0 : pos_inc[PW-1:0];
          idx_d   = (pos_inc >= n_cur) ? '0 : pos_inc[PW-1:0];
          k_d     = '0;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        rd_vld_d = 1'b1;
        idx_d    = (idx_inc >= n_q) ? '0 : idx_inc[PW-1:0];
        k_d      = k_q + PW'(1);
        if (CW'(k_q) == n_q - CW'(1)) begin
          state_d = ST_DRAIN1;
        end
      end
      ST_DRAIN1: begin
        state_d = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the previous result has been transferred
        if (!out_vld_q || out_ready_i) begin
          out_vld_d  = 1'b1;
          filtered_d = mac_res;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_count_q <= TAP_CNT_RST;
      wp_q        <= '0;
      n_q         <= CW'(1);
      k_q         <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      n_q       <= n_d;
      k_q       <= k_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        tap_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    filtered_q <= filtered_d;
  end

  assign out_valid_o = out_vld_q;
  assign filtered_o  = filtered_q;

  cff_store #(
    .DEPTH (MAX_TAPS),
    .AW    (PW)
  ) u_samples (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (smp_accept),
    .waddr_i (pos0),
    .wdata_i (sample_i),
    .raddr_i (idx_q),
    .rdata_o (smp_rd)
  );

  cff_store #(
    .DEPTH (MAX_TAPS),
    .AW    (PW)
  ) u_coefs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (coef_we),
    .waddr_i (PW'(coef_index_i)),
    .wdata_i (coef_value_i),
    .raddr_i (k_q),
    .rdata_o (coef_rd)
  );

  assign mac_ctrl.clear  = smp_accept;
  assign mac_ctrl.mul_en = rd_vld_q;

  cff_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef_rd),
    .sample_i (smp_rd),
    .result_o (mac_res)
  );

  a_tap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> ((CW'(k_q) < n_q) && (CW'(idx_q) < n_q)))
    else $error("tap counter or read index beyond taps in use");

  a_n_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> ((n_q != '0) && (32'(n_q) <= MAX_TAPS)))
    else $error("taps in use out of range");

  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_accept |=> (state_q == ST_MAC))
    else $error("sample transfer did not start the tap sequence");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> (out_vld_q && $stable(filtered_q)))
    else $error("pending result lost or changed");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circular FIR filter. A queue-fed driver sends
// sample and coefficient-write items with random gaps. A local model of the
// sample store, the coefficients and the write position predicts each
// filtered value. A monitor takes results under random back-pressure and
// compares them in order. The tap count is changed between idle phases,
// with zero, the maximum and values above the maximum among the settings.
// ----------------------------------------------------------------------------
module tb_top;
  import cff_pkg::*;

  localparam int unsigned TIMEOUT_CYC = 800000;
  localparam int unsigned SETTLE_CYC  = 20;
  localparam int unsigned PHASES      = 20;
  localparam int unsigned PHASE_ITEMS = 55;

  typedef struct {
    op_e                         op;
    logic signed [SAMPLE_W-1:0]  smp;
    logic [COEF_IDX_W-1:0]       cidx;
    logic signed [COEF_W-1:0]    cval;
    bit                          hold;  // wait for every result before sending
  } item_t;

  logic                        clk_i     = 1'b0;
  logic                        rst_ni    = 1'b0;
  logic                        in_valid  = 1'b0;
  op_e                         op_d      = OP_FILTER;
  logic signed [SAMPLE_W-1:0]  smp_d     = '0;
  logic [COEF_IDX_W-1:0]       cidx_d    = '0;
  logic signed [COEF_W-1:0]    cval_d    = '0;
  logic                        out_ready = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic [TAP_CNT_W-1:0]        cfg_wdata = '0;
  logic                        in_ready;
  logic                        out_valid;
  logic signed [SAMPLE_W-1:0]  filtered;

  // model state
  logic signed [SAMPLE_W-1:0]  sample_mem [MAX_TAPS_DEF] = '{default: '0};
  logic signed [COEF_W-1:0]    coef_mem   [MAX_TAPS_DEF] = '{default: '0};
  int unsigned                 wr_pos  = 0;
  logic [TAP_CNT_W-1:0]        tap_cfg = TAP_CNT_RST;

  item_t                       stim_q[$];
  logic signed [SAMPLE_W-1:0]  filtered_q[$];
  item_t                       tx_item;
  int unsigned                 tx_idle   = 0;
  bit                          tx_burst  = 1'b0;
  int unsigned                 rx_stall  = 0;
  bit                          rx_burst  = 1'b0;
  logic signed [SAMPLE_W-1:0]  exp_val;
  int unsigned                 errors    = 0;
  int unsigned                 cycles    = 0;
  int unsigned                 tap_new;
  bit                          hold_now;
  op_e                         rnd_op;
  logic signed [15:0]          rnd_smp;
  logic signed [15:0]          rnd_cval;

  circular_fir_filter_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .operation_i  (op_d),
    .sample_i     (smp_d),
    .coef_index_i (cidx_d),
    .coef_value_i (cval_d),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .filtered_o   (filtered),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Store a sample, advance the position and return the saturated sum.
  function automatic logic signed [SAMPLE_W-1:0] filter_sample(
    logic signed [SAMPLE_W-1:0] smp
  );
    int unsigned n;
    int unsigned pos;
    int unsigned idx;
    longint      acc;
    n = (tap_cfg == 0) ? 1 : ((tap_cfg > MAX_TAPS_DEF) ? MAX_TAPS_DEF : tap_cfg);
    pos = (wr_pos >= n) ? 0 : wr_pos;
    sample_mem[pos] = smp;
    pos = (pos + 1 >= n) ? 0 : pos + 1;
    wr_pos = pos;
    acc = 0;
    for (int unsigned k = 0; k < n; k++) begin
      idx = (pos + k >= n) ? pos + k - n : pos + k;
      acc += longint'(coef_mem[k]) * longint'(sample_mem[idx]);
    end
    acc = acc >>> FRAC_W;
    if (acc > longint'(SAT_MAX)) acc = longint'(SAT_MAX);
    if (acc < longint'(SAT_MIN)) acc = longint'(SAT_MIN);
    return acc[SAMPLE_W-1:0];
  endfunction

  // Mostly short gaps, a few long ones, none in a burst.
  function automatic int unsigned pick_idle(bit burst);
    int unsigned r;
    r = $urandom_range(99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_item(op_e op, logic signed [15:0] smp, logic [2:0] cidx,
                           logic signed [15:0] cval, bit hold);
    item_t it;
    it.op   = op;
    it.smp  = smp;
    it.cidx = cidx;
    it.cval = cval;
    it.hold = hold;
    stim_q.push_back(it);
  endtask

  task automatic wait_idle();
    // sample away from the rising edge so the driver's updates have settled
    do @(negedge clk_i);
    while (stim_q.size() != 0 || in_valid || filtered_q.size() != 0);
    // let a trailing coefficient write finish
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // input side: present items and update the model on each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (op_d == OP_FILTER) filtered_q.push_back(filter_sample(smp_d));
        else coef_mem[cidx_d] = cval_d;
      end
      if (!in_valid || in_ready) begin
        if (tx_idle != 0) begin
          tx_idle--;
          in_valid <= 1'b0;
        end else if (stim_q.size() != 0 && (!stim_q[0].hold || filtered_q.size() == 0)) begin
          tx_item = stim_q.pop_front();
          in_valid <= 1'b1;
          op_d     <= tx_item.op;
          smp_d    <= tx_item.smp;
          cidx_d   <= tx_item.cidx;
          cval_d   <= tx_item.cval;
          if ($urandom_range(39) == 0) tx_burst = !tx_burst;
          tx_idle = pick_idle(tx_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: random back-pressure and in-order comparison
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          $error("filtered: expected nothing, actual %0d", filtered);
          errors++;
        end else begin
          exp_val = filtered_q.pop_front();
          if (filtered !== exp_val) begin
            $error("filtered: expected %0d, actual %0d", exp_val, filtered);
            errors++;
          end
        end
      end
      if (rx_stall != 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(49) == 0) rx_burst = !rx_burst;
        if (!rx_burst && $urandom_range(3) == 0) rx_stall = pick_idle(1'b0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= TIMEOUT_CYC) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset tap count: full-scale coefficients, then runs of extreme samples
    // that drive the sum into both saturation limits.
    for (int k = 0; k < 8; k++)
      push_item(OP_COEF, 16'($urandom), 3'(k), (k == 7) ? 16'sh7fff : 16'sh8000, 1'b0);
    repeat (6) push_item(OP_FILTER, 16'sh8000, 3'($urandom), 16'($urandom), 1'b0);
    repeat (8) push_item(OP_FILTER, 16'sh7fff, 3'($urandom), 16'($urandom), 1'b0);
    push_item(OP_FILTER, 16'sh0000, 3'($urandom), 16'($urandom), 1'b0);
    push_item(OP_FILTER, 16'shffff, 3'($urandom), 16'($urandom), 1'b0);
    push_item(OP_FILTER, 16'sh0001, 3'($urandom), 16'($urandom), 1'b0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       tap_new = 1;   // position left beyond the new length
        1:       tap_new = 0;
        2:       tap_new = 15;
        3:       tap_new = 9;
        4:       tap_new = 8;
        default: tap_new = $urandom_range(0, 15);
      endcase
      @(posedge clk_i);
      cfg_we    <= 1'b1;
      cfg_wdata <= TAP_CNT_W'(tap_new);
      tap_cfg   = TAP_CNT_W'(tap_new);
      @(posedge clk_i);
      cfg_we    <= 1'b0;

      if (p == 0) begin
        push_item(OP_FILTER, 16'sh8000, 3'($urandom), 16'($urandom), 1'b0);
        push_item(OP_FILTER, 16'sh7fff, 3'($urandom), 16'($urandom), 1'b0);
        push_item(OP_COEF, 16'($urandom), 3'd0, 16'sh7fff, 1'b0);
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        hold_now = (i == PHASE_ITEMS / 2) || ($urandom_range(49) == 0);
        rnd_op   = ($urandom_range(99) < 78) ? OP_FILTER : OP_COEF;
        case ($urandom_range(9))
          0:       rnd_smp = 16'sh8000;
          1:       rnd_smp = 16'sh7fff;
          default: rnd_smp = 16'($urandom);
        endcase
        case ($urandom_range(7))
          0:       rnd_cval = 16'sh8000;
          1:       rnd_cval = 16'sh7fff;
          default: rnd_cval = $signed(16'($urandom)) >>> $urandom_range(0, 5);
        endcase
        push_item(rnd_op, rnd_smp, 3'($urandom), rnd_cval, hold_now);
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
